### hw/rtl/wcc_pkg.sv
// ----------------------------------------------------------------------------
// wcc_pkg
// Shared types and constants of the window co-occurrence counter: operation
// codes, beat payloads and default sizes.
// ----------------------------------------------------------------------------
package wcc_pkg;

  localparam int FEATURES_DEF     = 256;
  localparam int WINDOW_PARTS_DEF = 64;
  localparam int COUNT_BITS_DEF   = 32;

  localparam int PART_W  = 8;
  localparam int OP_W    = 3;
  localparam int TOTAL_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_PART   = 3'd0,
    OP_END_WORD   = 3'd1,
    OP_END_WINDOW = 3'd2,
    OP_READ_COOC  = 3'd3,
    OP_READ_FREQ  = 3'd4
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PART_W-1:0] part_id;
    logic [PART_W-1:0] col_id;
  } item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] read_value;
    logic [TOTAL_W-1:0] windows_seen;
    logic [TOTAL_W-1:0] words_seen;
    logic [TOTAL_W-1:0] parts_seen;
    logic               overflow;
  } result_t;

endpackage

### hw/rtl/window_cooccurrence_counter.sv
// ----------------------------------------------------------------------------
// window_cooccurrence_counter
// Counts part frequencies and cross-word part co-occurrences over windows
// and answers read beats for single counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (item_valid/item_ready) carry an op, a part and a column.
//   Every input beat yields exactly one output beat (result_valid/
//   result_ready) holding the read count (zero unless a read op) and the
//   window, word and part totals plus the sticky overflow flag, all taken
//   after the beat's update.
//   End word, end window and dropped ops go from accept straight to the
//   result stage; reads first pass a RAM read state; an add updates
//   the frequency RAM and, unless the open word is the first of its
//   window, runs the pair scan over the parts held in earlier words of
//   the window (at most WINDOW_PARTS), one co-occurrence read-modify-write
//   per cycle through the single port pair of the matrix RAM.
//   One item is in work at a time; a new beat is taken as soon as the
//   previous result sits in the output register, even if it waits there.
//   A stalled receiver holds the result register; the block then finishes
//   the item in work and waits to hand it over.
//   Reset starts a clearing pass over all FEATURES*FEATURES matrix
//   addresses that zeroes the matrix and frequency RAMs; no beat is taken
//   until it ends.
// ----------------------------------------------------------------------------
module window_cooccurrence_counter #(
  parameter int FEATURES     = wcc_pkg::FEATURES_DEF,
  parameter int WINDOW_PARTS = wcc_pkg::WINDOW_PARTS_DEF,
  parameter int COUNT_BITS   = wcc_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  wcc_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output wcc_pkg::result_t result
);
  import wcc_pkg::*;

  localparam int FA_W   = $clog2(FEATURES);
  localparam int CDEPTH = FEATURES * FEATURES;
  localparam int CA_W   = $clog2(CDEPTH);
  localparam int BA_W   = $clog2(WINDOW_PARTS);
  localparam int FL_W   = $clog2(WINDOW_PARTS + 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_FREQ  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_READ  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e state, state_next;

  // Clearing pass.
  logic [CA_W-1:0] clr_addr;

  // Window bookkeeping and totals.
  logic [FL_W-1:0]    buffer_fill;
  logic [FL_W-1:0]    word_start;
  logic [TOTAL_W-1:0] window_total;
  logic [TOTAL_W-1:0] word_total;
  logic [TOTAL_W-1:0] part_total;
  logic               overflow_flag;

  // Item in work.
  logic [FA_W-1:0]    part_q;
  logic               rd_cooc;
  logic [TOTAL_W-1:0] read_value;

  logic accept;
  logic part_ok;
  logic col_ok;
  logic resp_load;

  // Memory ports.
  logic                  freq_wr_en;
  logic [FA_W-1:0]       freq_wr_addr;
  logic [COUNT_BITS-1:0] freq_wr_data;
  logic                  freq_rd_en;
  logic [COUNT_BITS-1:0] freq_rd_data;
  logic [COUNT_BITS-1:0] freq_bump;

  logic                  cooc_wr_en;
  logic [CA_W-1:0]       cooc_wr_addr;
  logic [COUNT_BITS-1:0] cooc_wr_data;
  logic                  cooc_rd_en;
  logic [CA_W-1:0]       cooc_rd_addr;
  logic [COUNT_BITS-1:0] cooc_rd_data;

  logic                  buf_wr_en;
  logic                  buf_rd_en;
  logic [BA_W-1:0]       buf_rd_addr;
  logic [PART_W-1:0]     buf_rd_data;

  logic                  scan_start;
  logic                  scan_busy;
  logic                  scan_cooc_rd_en;
  logic [CA_W-1:0]       scan_cooc_rd_addr;
  logic                  scan_cooc_wr_en;
  logic [CA_W-1:0]       scan_cooc_wr_addr;
  logic [COUNT_BITS-1:0] scan_cooc_wr_data;

  logic [COUNT_BITS-1:0] rd_count;
  logic [63:0]           rd_wide;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign part_ok    = 32'(item.part_id) < FEATURES;
  assign col_ok     = 32'(item.col_id) < FEATURES;
  assign resp_load  = (state == S_RESP) && (!result_valid || result_ready);

  // ---- Frequency RAM: cleared; read on accept, an add written back in the next cycle
  assign freq_rd_en   = accept && part_ok &&
                        ((item.op == OP_ADD_PART) || (item.op == OP_READ_FREQ));
  assign freq_bump    = (freq_rd_data == '1) ? freq_rd_data
                                             : freq_rd_data + COUNT_BITS'(1);
  assign freq_wr_en   = (state == S_CLEAR) ? (32'(clr_addr) < FEATURES) : (state == S_FREQ);
  assign freq_wr_addr = (state == S_CLEAR) ? clr_addr[FA_W-1:0] : part_q;
  assign freq_wr_data = (state == S_CLEAR) ? '0 : freq_bump;

  wcc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (FEATURES)
  ) u_freq_ram (
    .clk     (clk),
    .wr_en   (freq_wr_en),
    .wr_addr (freq_wr_addr),
    .wr_data (freq_wr_data),
    .rd_en   (freq_rd_en),
    .rd_addr (FA_W'(item.part_id)),
    .rd_data (freq_rd_data)
  );

  // ---- Co-occurrence RAM: cleared, scanned, or read for a read beat -----
  assign cooc_wr_en   = (state == S_CLEAR) || scan_cooc_wr_en;
  assign cooc_wr_addr = (state == S_CLEAR) ? clr_addr : scan_cooc_wr_addr;
  assign cooc_wr_data = (state == S_CLEAR) ? '0 : scan_cooc_wr_data;
  assign cooc_rd_en   = scan_cooc_rd_en ||
                        (accept && (item.op == OP_READ_COOC) && part_ok && col_ok);
  assign cooc_rd_addr = scan_cooc_rd_en ? scan_cooc_rd_addr
                        : CA_W'(32'(item.part_id) * FEATURES + 32'(item.col_id));

  wcc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (CDEPTH)
  ) u_cooc_ram (
    .clk     (clk),
    .wr_en   (cooc_wr_en),
    .wr_addr (cooc_wr_addr),
    .wr_data (cooc_wr_data),
    .rd_en   (cooc_rd_en),
    .rd_addr (cooc_rd_addr),
    .rd_data (cooc_rd_data)
  );

  // ---- Window buffer: store the part while the scan only reads older slots
  assign buf_wr_en = (state == S_FREQ) && (32'(buffer_fill) < WINDOW_PARTS);

  wcc_ram #(
    .WIDTH (PART_W),
    .DEPTH (WINDOW_PARTS)
  ) u_window_buf (
    .clk     (clk),
    .wr_en   (buf_wr_en),
    .wr_addr (buffer_fill[BA_W-1:0]),
    .wr_data (PART_W'(part_q)),
    .rd_en   (buf_rd_en),
    .rd_addr (buf_rd_addr),
    .rd_data (buf_rd_data)
  );

  // ---- Pair scan over the earlier words of the window --------------------
  assign scan_start = (state == S_FREQ) && (word_start != '0);

  wcc_pair_scan #(
    .FEATURES     (FEATURES),
    .WINDOW_PARTS (WINDOW_PARTS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_pair_scan (
    .clk          (clk),
    .rst          (rst),
    .start        (scan_start),
    .part         (part_q),
    .count        (word_start),
    .busy         (scan_busy),
    .buf_rd_en    (buf_rd_en),
    .buf_rd_addr  (buf_rd_addr),
    .buf_rd_data  (buf_rd_data),
    .cooc_rd_en   (scan_cooc_rd_en),
    .cooc_rd_addr (scan_cooc_rd_addr),
    .cooc_rd_data (cooc_rd_data),
    .cooc_wr_en   (scan_cooc_wr_en),
    .cooc_wr_addr (scan_cooc_wr_addr),
    .cooc_wr_data (scan_cooc_wr_data)
  );

  // Select the count to read and widen it for the clip to the 32-bit read field.
  assign rd_count = rd_cooc ? cooc_rd_data : freq_rd_data;
  assign rd_wide  = 64'(rd_count);

  // ---- Sequencer ---------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == CA_W'(CDEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (item.op == OP_ADD_PART && part_ok) begin
            state_next = S_FREQ;
          end else if ((item.op == OP_READ_FREQ && part_ok) ||
                       (item.op == OP_READ_COOC && part_ok && col_ok)) begin
            state_next = S_READ;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_FREQ: state_next = (word_start != '0) ? S_SCAN : S_RESP;
      S_SCAN: begin
        if (!scan_busy) begin
          state_next = S_RESP;
        end
      end
      S_READ: state_next = S_RESP;
      S_RESP: begin
        if (resp_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      buffer_fill   <= '0;
      word_start    <= '0;
      window_total  <= '0;
      word_total    <= '0;
      part_total    <= '0;
      overflow_flag <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + CA_W'(1);
      end
      // Hand the result over; drop the valid once the receiver takes it.
      if (resp_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        unique case (item.op)
          OP_END_WORD: begin
            word_start <= buffer_fill;
            if (word_total != '1) begin
              word_total <= word_total + TOTAL_W'(1);
            end
          end
          OP_END_WINDOW: begin
            buffer_fill <= '0;
            word_start  <= '0;
            if (window_total != '1) begin
              window_total <= window_total + TOTAL_W'(1);
            end
          end
          default: ;
        endcase
      end
      if (state == S_FREQ) begin
        if (part_total != '1) begin
          part_total <= part_total + TOTAL_W'(1);
        end
        if (32'(buffer_fill) < WINDOW_PARTS) begin
          buffer_fill <= buffer_fill + FL_W'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
      end
    end
  end

  // Payload registers of the item in work and of the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      part_q     <= FA_W'(item.part_id);
      rd_cooc    <= (item.op == OP_READ_COOC);
      read_value <= '0;
    end
    if (state == S_READ) begin
      read_value <= (rd_wide > 64'hFFFF_FFFF) ? '1 : rd_wide[TOTAL_W-1:0];
    end
    if (resp_load) begin
      result.read_value   <= read_value;
      result.windows_seen <= window_total;
      result.words_seen   <= word_total;
      result.parts_seen   <= part_total;
      result.overflow     <= overflow_flag;
    end
  end

endmodule

### hw/rtl/wcc_ram.sv
// ----------------------------------------------------------------------------
// wcc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (old contents on a same-address read and write).
// ----------------------------------------------------------------------------
module wcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/wcc_pair_scan.sv
// ----------------------------------------------------------------------------
// wcc_pair_scan
// Pair scan engine: walks the earlier-word parts of the window buffer and
// bumps one co-occurrence entry per part in a three-stage read-modify-write
// pipeline, forwarding the last written count on a back-to-back address hit.
// ----------------------------------------------------------------------------
module wcc_pair_scan #(
  parameter int FEATURES     = wcc_pkg::FEATURES_DEF,
  parameter int WINDOW_PARTS = wcc_pkg::WINDOW_PARTS_DEF,
  parameter int COUNT_BITS   = wcc_pkg::COUNT_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic [$clog2(FEATURES)-1:0]               part,
  input  logic [$clog2(WINDOW_PARTS+1)-1:0]         count,
  output logic                                      busy,
  output logic                                      buf_rd_en,
  output logic [$clog2(WINDOW_PARTS)-1:0]           buf_rd_addr,
  input  logic [wcc_pkg::PART_W-1:0]                buf_rd_data,
  output logic                                      cooc_rd_en,
  output logic [$clog2(FEATURES*FEATURES)-1:0]      cooc_rd_addr,
  input  logic [COUNT_BITS-1:0]                     cooc_rd_data,
  output logic                                      cooc_wr_en,
  output logic [$clog2(FEATURES*FEATURES)-1:0]      cooc_wr_addr,
  output logic [COUNT_BITS-1:0]                     cooc_wr_data
);
  import wcc_pkg::*;

  localparam int FA_W = $clog2(FEATURES);
  localparam int CA_W = $clog2(FEATURES * FEATURES);
  localparam int BA_W = $clog2(WINDOW_PARTS);
  localparam int FL_W = $clog2(WINDOW_PARTS + 1);

  logic [FL_W-1:0]       issue_k;
  logic [FL_W-1:0]       limit;
  logic                  active;
  logic [FA_W-1:0]       part_q;
  logic                  b_vld;
  logic                  c_vld;
  logic [CA_W-1:0]       c_addr;
  logic                  fwd_vld;
  logic [CA_W-1:0]       fwd_addr;
  logic [COUNT_BITS-1:0] fwd_data;
  logic [COUNT_BITS-1:0] src_count;

  assign buf_rd_en   = active && (issue_k < limit);
  assign buf_rd_addr = issue_k[BA_W-1:0];

  // Row comes from the buffer, column is the part being added.
  assign cooc_rd_en   = b_vld;
  assign cooc_rd_addr = CA_W'(32'(buf_rd_data) * FEATURES + 32'(part_q));

  // A read issued in the cycle of the previous write saw the stale count.
  assign src_count    = (fwd_vld && (fwd_addr == c_addr)) ? fwd_data : cooc_rd_data;
  assign cooc_wr_en   = c_vld;
  assign cooc_wr_addr = c_addr;
  assign cooc_wr_data = (src_count == '1) ? src_count : src_count + COUNT_BITS'(1);

  assign busy = active || b_vld || c_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      b_vld   <= 1'b0;
      c_vld   <= 1'b0;
      fwd_vld <= 1'b0;
    end else begin
      b_vld   <= buf_rd_en;
      c_vld   <= b_vld;
      fwd_vld <= c_vld;
      if (start) begin
        active <= 1'b1;
      end else if (!buf_rd_en) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      issue_k <= '0;
      limit   <= count;
      part_q  <= part;
    end else if (buf_rd_en) begin
      issue_k <= issue_k + FL_W'(1);
    end
    c_addr   <= cooc_rd_addr;
    fwd_addr <= cooc_wr_addr;
    fwd_data <= cooc_wr_data;
  end

endmodule
